>>> hw/rtl/aewd_pkg.sv
package aewd_pkg;

    // Word types, taken from bits 31..30 of a readout word.
    localparam logic [1:0] TYPE_DATA   = 2'd0;
    localparam logic [1:0] TYPE_HEADER = 2'd1;
    localparam logic [1:0] TYPE_UNUSED = 2'd2;
    localparam logic [1:0] TYPE_EOE    = 2'd3;

    // Timestamp modes.
    localparam logic [1:0] MODE_COUNTER   = 2'd0;
    localparam logic [1:0] MODE_EOE_STAMP = 2'd1;
    localparam logic [1:0] MODE_IGNORE    = 2'd2;
    localparam logic [1:0] MODE_EXT_STAMP = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_HIT         = 3'd0;
    localparam logic [2:0] KIND_BAD_HEADER  = 3'd1;
    localparam logic [2:0] KIND_BAD_DATA    = 3'd2;
    localparam logic [2:0] KIND_NO_STAMP    = 3'd3;
    localparam logic [2:0] KIND_STORE_FULL  = 3'd4;

    // Configuration register indexes.
    localparam logic [7:0] REG_TIMESTAMP_MODE = 8'd0;
    localparam logic [7:0] REG_MODULE_NUMBER  = 8'd1;

    // Word pattern constants.
    localparam logic [9:0]  HIT_TAG        = 10'd16;
    localparam logic [7:0]  HEADER_TAG     = 8'h40;
    localparam logic [15:0] EXT_STAMP_TAG  = 16'd1152;
    localparam logic [15:0] CHARGE_OVERFLOW = 16'hFFFF;
    localparam logic [63:0] STAMP_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] EXTRAS_HELD    = 32'hFFFF_0032;

    // Width of one held hit: channel and charge.
    localparam int HELD_W = 21;

    // What the decoded word asks of the controller.
    typedef logic [1:0] act_t;
    localparam act_t ACT_NONE    = 2'd0;
    localparam act_t ACT_SINGLE  = 2'd1;
    localparam act_t ACT_RELEASE = 2'd2;

    // Source of a record loaded into the output register.
    typedef logic [1:0] src_t;
    localparam src_t SRC_SINGLE = 2'd0;
    localparam src_t SRC_HELD   = 2'd1;
    localparam src_t SRC_TAIL   = 2'd2;

    typedef struct packed {
        logic load_word;
        logic commit;
        logic ram_rd;
        logic idx_clear;
        logic idx_inc;
        logic emit;
        src_t emit_src;
        logic emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        act_t act;
        logic out_free;
        logic idx_last;
        logic has_tail;
    } dp_stat_t;

endpackage

>>> hw/rtl/aewd_ram.sv
module aewd_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/aewd_ctrl.sv
module aewd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  aewd_pkg::dp_stat_t   stat,
    output aewd_pkg::ctrl_cmd_t  cmd
);

    import aewd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.emit_src = SRC_SINGLE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_word = 1'b1;
                    state_next    = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (stat.act)
                    ACT_SINGLE:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.commit    = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.emit_src  = SRC_SINGLE;
                            cmd.emit_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        cmd.commit    = 1'b1;
                        cmd.idx_clear = 1'b1;
                        state_next    = S_RD;
                    end
                    default:
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = SRC_HELD;
                    cmd.emit_last = stat.idx_last && !stat.has_tail;
                    if (!stat.idx_last)
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                    else if (stat.has_tail)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = SRC_TAIL;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/aewd_datapath.sv
module aewd_datapath #(
    parameter int HIT_STORE_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [31:0]          data_word,
    input  aewd_pkg::ctrl_cmd_t  cmd,
    output aewd_pkg::dp_stat_t   stat,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [2:0]           kind,
    output logic [7:0]           module_id,
    output logic [4:0]           channel,
    output logic [15:0]          charge,
    output logic [63:0]          time_stamp,
    output logic [31:0]          extras_word,
    output logic [13:0]          mean_value,
    output logic                 last
);

    import aewd_pkg::*;

    localparam int CNT_W = $clog2(HIT_STORE_DEPTH + 1);
    localparam int AW    = (HIT_STORE_DEPTH > 1) ? $clog2(HIT_STORE_DEPTH) : 1;

    // Configuration.
    logic [1:0]  mode_reg;
    logic [7:0]  module_reg;

    // Block state.
    logic [31:0]      word_reg;
    logic [63:0]      event_count_reg;
    logic [13:0]      mean_reg;
    logic [13:0]      mean_next;
    logic [CNT_W-1:0] held_count_reg;
    logic [15:0]      stamp_high_reg;
    logic             stamp_valid_reg;

    // Release bookkeeping.
    logic [CNT_W-1:0] rel_count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             tail_reg;
    logic [2:0]       tail_kind_reg;
    logic [63:0]      rel_ts_reg;

    // Output register.
    logic             out_valid_reg;

    // Decode.
    logic [1:0]  wtype;
    logic        is_hit;
    logic        hdr_ok;
    logic        is_ext;
    logic        is_zero;
    logic        held_full;
    logic [13:0] amp;
    logic [4:0]  hit_channel;
    logic [15:0] hit_charge;
    logic [14:0] mean_sum;
    act_t        act;
    logic [2:0]  sgl_kind;
    logic        sgl_hit;
    logic        tail_flag;
    logic [2:0]  tail_kind;
    logic [63:0] rel_ts;
    logic        store_wr;
    logic [HELD_W-1:0] ram_rd_data;

    assign wtype       = word_reg[31:30];
    assign is_hit      = (word_reg[31:22] == HIT_TAG);
    assign hdr_ok      = (word_reg[31:24] == HEADER_TAG);
    assign is_ext      = (word_reg[31:16] == EXT_STAMP_TAG);
    assign is_zero     = (word_reg == 32'd0);
    assign held_full   = (held_count_reg == CNT_W'(HIT_STORE_DEPTH));
    assign amp         = word_reg[13:0];
    assign hit_channel = word_reg[20:16];
    assign hit_charge  = word_reg[14] ? CHARGE_OVERFLOW : {2'b00, amp};
    assign mean_sum    = {1'b0, mean_reg} + {1'b0, amp};
    assign mean_next   = (mean_reg == 14'd0) ? amp : mean_sum[14:1];

    always_comb
    begin
        act       = ACT_NONE;
        sgl_kind  = KIND_HIT;
        sgl_hit   = 1'b0;
        tail_flag = 1'b0;
        tail_kind = KIND_BAD_HEADER;
        rel_ts    = STAMP_ALL_ONES;
        unique case (mode_reg)
            MODE_COUNTER:
            begin
                unique case (wtype)
                    TYPE_HEADER:
                    begin
                        if (!hdr_ok)
                        begin
                            act      = ACT_SINGLE;
                            sgl_kind = KIND_BAD_HEADER;
                        end
                    end
                    TYPE_DATA:
                    begin
                        if (is_hit)
                        begin
                            act      = ACT_SINGLE;
                            sgl_kind = KIND_HIT;
                            sgl_hit  = 1'b1;
                        end
                        else if (!is_zero)
                        begin
                            act      = ACT_SINGLE;
                            sgl_kind = KIND_BAD_DATA;
                        end
                    end
                    default:
                    begin
                        act = ACT_NONE;
                    end
                endcase
            end
            MODE_EOE_STAMP, MODE_EXT_STAMP:
            begin
                unique case (wtype)
                    TYPE_HEADER:
                    begin
                        act       = ACT_RELEASE;
                        tail_flag = !hdr_ok;
                        tail_kind = KIND_BAD_HEADER;
                    end
                    TYPE_DATA:
                    begin
                        if (is_hit)
                        begin
                            if (held_full)
                            begin
                                act      = ACT_SINGLE;
                                sgl_kind = KIND_STORE_FULL;
                            end
                        end
                        else if (is_ext && (mode_reg == MODE_EXT_STAMP))
                        begin
                            act = ACT_NONE;
                        end
                        else if (!is_zero)
                        begin
                            act      = ACT_SINGLE;
                            sgl_kind = KIND_BAD_DATA;
                        end
                    end
                    TYPE_EOE:
                    begin
                        act = ACT_RELEASE;
                        if (mode_reg == MODE_EOE_STAMP)
                        begin
                            rel_ts = {34'd0, word_reg[29:0]};
                        end
                        else if (stamp_valid_reg)
                        begin
                            // The high part sits above the 30 low bits, so no add is needed.
                            rel_ts = {18'd0, stamp_high_reg, word_reg[29:0]};
                        end
                        else
                        begin
                            tail_flag = 1'b1;
                            tail_kind = KIND_NO_STAMP;
                        end
                    end
                    default:
                    begin
                        act = ACT_NONE;
                    end
                endcase
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase

        // With nothing held, a release reduces to its trailing error record, if any.
        if ((act == ACT_RELEASE) && (held_count_reg == '0))
        begin
            act      = tail_flag ? ACT_SINGLE : ACT_NONE;
            sgl_kind = tail_kind;
        end
    end

    assign store_wr = cmd.commit && (mode_reg != MODE_COUNTER) && (mode_reg != MODE_IGNORE)
                      && (wtype == TYPE_DATA) && is_hit && !held_full;

    assign stat.act      = act;
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.idx_last = ((idx_reg + CNT_W'(1)) == rel_count_reg);
    assign stat.has_tail = tail_reg;

    aewd_ram #(
        .WIDTH (HELD_W),
        .DEPTH (HIT_STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (held_count_reg[AW-1:0]),
        .wr_data ({hit_channel, hit_charge}),
        .rd_en   (cmd.ram_rd),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_COUNTER;
            module_reg      <= 8'd0;
            event_count_reg <= 64'd0;
            mean_reg        <= 14'd0;
            held_count_reg  <= '0;
            stamp_high_reg  <= 16'd0;
            stamp_valid_reg <= 1'b0;
            rel_count_reg   <= '0;
            tail_reg        <= 1'b0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_TIMESTAMP_MODE)
                begin
                    mode_reg <= cfg_data[1:0];
                end
                else if (cfg_index == REG_MODULE_NUMBER)
                begin
                    module_reg <= cfg_data;
                end
            end

            if (cmd.commit)
            begin
                unique case (mode_reg)
                    MODE_COUNTER:
                    begin
                        if ((wtype == TYPE_DATA) && is_hit)
                        begin
                            mean_reg <= mean_next;
                        end
                        if (wtype == TYPE_EOE)
                        begin
                            event_count_reg <= event_count_reg + 64'd1;
                        end
                    end
                    MODE_EOE_STAMP, MODE_EXT_STAMP:
                    begin
                        if ((wtype == TYPE_HEADER) || (wtype == TYPE_EOE))
                        begin
                            rel_count_reg  <= held_count_reg;
                            held_count_reg <= '0;
                            tail_reg       <= tail_flag;
                        end
                        if (wtype == TYPE_HEADER)
                        begin
                            stamp_high_reg  <= 16'd0;
                            stamp_valid_reg <= 1'b0;
                        end
                        if (store_wr)
                        begin
                            held_count_reg <= held_count_reg + CNT_W'(1);
                        end
                        if ((wtype == TYPE_DATA) && !is_hit && is_ext
                            && (mode_reg == MODE_EXT_STAMP))
                        begin
                            stamp_high_reg  <= word_reg[15:0];
                            stamp_valid_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            word_reg <= data_word;
        end

        if (cmd.commit)
        begin
            tail_kind_reg <= tail_kind;
            rel_ts_reg    <= rel_ts;
        end

        if (cmd.emit)
        begin
            module_id <= module_reg;
            last      <= cmd.emit_last;
            unique case (cmd.emit_src)
                SRC_HELD:
                begin
                    kind        <= KIND_HIT;
                    channel     <= ram_rd_data[20:16];
                    charge      <= ram_rd_data[15:0];
                    time_stamp  <= rel_ts_reg;
                    extras_word <= EXTRAS_HELD;
                    mean_value  <= mean_reg;
                end
                SRC_TAIL:
                begin
                    kind        <= tail_kind_reg;
                    channel     <= 5'd0;
                    charge      <= 16'd0;
                    time_stamp  <= 64'd0;
                    extras_word <= 32'd0;
                    mean_value  <= 14'd0;
                end
                default:
                begin
                    kind        <= sgl_kind;
                    channel     <= sgl_hit ? hit_channel : 5'd0;
                    charge      <= sgl_hit ? hit_charge : 16'd0;
                    time_stamp  <= sgl_hit ? event_count_reg : 64'd0;
                    extras_word <= 32'd0;
                    mean_value  <= sgl_hit ? mean_next : 14'd0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/adc_event_word_decoder_core.sv
// Decodes readout words of a 32-channel ADC module into hit and error records. A word
// is taken, then decoded in the next cycle, and no new word is taken until the block
// is through with it. A header or end-of-event word in modes 1 and 3 releases the held
// hits, then an error record when one trails them: each held hit takes a registered
// read of the hit store and then a load of the single output register, which waits
// while the output is stalled. A finished record waits in the output register while
// the next word is accepted. The hit store needs no clearing after reset; a fill count
// tracks which entries hold hits. Configuration writes are always ready and must be
// issued while no word is in progress.
module adc_event_word_decoder_core #(
    parameter int HIT_STORE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  module_id,
    output logic [4:0]  channel,
    output logic [15:0] charge,
    output logic [63:0] time_stamp,
    output logic [31:0] extras_word,
    output logic [13:0] mean_value,
    output logic        last
);

    import aewd_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    aewd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    aewd_datapath #(
        .HIT_STORE_DEPTH (HIT_STORE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_word   (data_word),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .kind        (kind),
        .module_id   (module_id),
        .channel     (channel),
        .charge      (charge),
        .time_stamp  (time_stamp),
        .extras_word (extras_word),
        .mean_value  (mean_value),
        .last        (last)
    );

    // An accepted word keeps the block busy for at least its decode cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after a beat");

    // A record is loaded only when the output register is empty or being drained.
    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("record loaded over a stalled output beat");

    // The decode cycle never overlaps with taking a new word.
    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.emit || cmd.ram_rd) |-> !cmd.load_word)
        else $error("new word loaded while a word is still in progress");

endmodule
